/* sv/pixel_tone_curve_unit_defines.svh */
// Assertion macros for the pixel tone curve unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PIXEL_TONE_CURVE_UNIT_DEFINES_SVH
`define PIXEL_TONE_CURVE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PTC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define PTC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/ptc_pkg.sv */
// Shared types, constants and the sine table sample function for the tone curve unit.
// No dependencies; used by ptc_lane and pixel_tone_curve_unit.
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

  localparam int CHAN_W      = 16;
  localparam int NUM_CH      = 4;
  localparam int GAIN_W      = 16;
  localparam int MASK_W      = 4;
  localparam int FR_W        = 15;
  localparam int PROD_W      = 33;
  localparam int ACC_W       = 36;
  localparam int UNIT_Q15    = 32768;
  localparam int LANE_STAGES = 5;
  localparam int PIPE_STAGES = LANE_STAGES + 1;

  // APB register map, one 32-bit word per register
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [2:0] REG_CONSTANT_GAIN       = 3'd0;
  localparam logic [2:0] REG_LINEAR_GAIN         = 3'd1;
  localparam logic [2:0] REG_SQUARE_GAIN         = 3'd2;
  localparam logic [2:0] REG_REVERSE_SQUARE_GAIN = 3'd3;
  localparam logic [2:0] REG_SINE_STEP_GAIN      = 3'd4;
  localparam logic [2:0] REG_CHANNEL_MASK        = 3'd5;

  localparam logic [GAIN_W-1:0] CONSTANT_GAIN_RST = 16'd0;
  localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST   = 16'd4096;
  localparam logic [GAIN_W-1:0] OTHER_GAIN_RST    = 16'd0;
  localparam logic [MASK_W-1:0] CHANNEL_MASK_RST  = 4'hF;

  localparam logic signed [63:0] PI_Q30   = 64'sd3373259426;
  localparam logic signed [63:0] UNIT_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic [GAIN_W-1:0] constant_gain;
    logic [GAIN_W-1:0] linear_gain;
    logic [GAIN_W-1:0] square_gain;
    logic [GAIN_W-1:0] reverse_square_gain;
    logic [GAIN_W-1:0] sine_step_gain;
  } ptc_gains_t;

  typedef struct packed {
    logic [LANE_STAGES-1:0] load;
  } ptc_ctrl_t;

  // (1 - cos(th))/2 in Q15 for th in Q30, Taylor series by Horner.
  // Only evaluated at elaboration to build the sine table.
  function automatic logic [CHAN_W-1:0] ptc_half_sample(input logic signed [63:0] th);
    logic signed [63:0] th2;
    logic signed [63:0] acc;
    logic signed [63:0] h;
    th2 = (th * th) >>> 30;
    acc = UNIT_Q30;
    acc = UNIT_Q30 - ((th2 * acc) >>> 30) / 64'sd182;
    acc = UNIT_Q30 - ((th2 * acc) >>> 30) / 64'sd132;
    acc = UNIT_Q30 - ((th2 * acc) >>> 30) / 64'sd90;
    acc = UNIT_Q30 - ((th2 * acc) >>> 30) / 64'sd56;
    acc = UNIT_Q30 - ((th2 * acc) >>> 30) / 64'sd30;
    acc = UNIT_Q30 - ((th2 * acc) >>> 30) / 64'sd12;
    acc = UNIT_Q30 - ((th2 * acc) >>> 30) / 64'sd2;
    h = UNIT_Q30 - acc;
    if (h < 0) begin
      h = 64'sd0;
    end
    h = (h + 64'sd32768) >>> 16;
    if (h > 64'sd16384) begin
      h = 64'sd16384;
    end
    return h[CHAN_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/ptc_lane.sv */
// One channel of the tone curve datapath: five register stages and the sine table ROM.
// Depends on ptc_pkg; load enables come from the top level's pipeline control.
`timescale 1ns / 1ps
`default_nettype none

module ptc_lane
  import ptc_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic              clk_i,
  input  wire ptc_gains_t        gains_i,
  input  wire ptc_ctrl_t         ctrl_i,
  input  wire logic [CHAN_W-1:0] chan_i,
  output logic      [CHAN_W-1:0] curve_o
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int P_W   = FR_W + IDX_W;
  localparam logic [P_W-1:0] DEPTH_K = P_W'(SINE_TABLE_DEPTH);

  // Each entry holds {rom[i], rom[i+1]} so a single read gives both interpolation points.
  // The last entry repeats rom[D]; its fraction is always zero.
  logic [2*CHAN_W-1:0] rom_w [SINE_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam int IA = gi;
    localparam int IB = (gi < SINE_TABLE_DEPTH) ? gi + 1 : gi;
    localparam int MA = (2 * IA <= SINE_TABLE_DEPTH) ? IA : SINE_TABLE_DEPTH - IA;
    localparam int MB = (2 * IB <= SINE_TABLE_DEPTH) ? IB : SINE_TABLE_DEPTH - IB;
    localparam logic signed [63:0] THA = (PI_Q30 * MA) / SINE_TABLE_DEPTH;
    localparam logic signed [63:0] THB = (PI_Q30 * MB) / SINE_TABLE_DEPTH;
    localparam logic [CHAN_W-1:0] HA = ptc_half_sample(THA);
    localparam logic [CHAN_W-1:0] HB = ptc_half_sample(THB);
    localparam logic [CHAN_W-1:0] VA =
      (2 * IA <= SINE_TABLE_DEPTH) ? HA : CHAN_W'(UNIT_Q15 - int'(HA));
    localparam logic [CHAN_W-1:0] VB =
      (2 * IB <= SINE_TABLE_DEPTH) ? HB : CHAN_W'(UNIT_Q15 - int'(HB));
    assign rom_w[gi] = {VA, VB};
  end

  // ---------------- stage 1: saturate, complement, table index ----------------
  logic [CHAN_W-1:0] xs_d, y_d;
  logic [P_W-1:0]    pos_d;
  logic [CHAN_W-1:0] xs1_q, y1_q;
  logic [IDX_W-1:0]  idx1_q;
  logic [FR_W-1:0]   fr1_q;

  always_comb begin
    xs_d  = (chan_i > CHAN_W'(UNIT_Q15)) ? CHAN_W'(UNIT_Q15) : chan_i;
    y_d   = CHAN_W'(17'd32768 - {1'b0, xs_d});
    pos_d = P_W'(xs_d) * DEPTH_K;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      xs1_q  <= xs_d;
      y1_q   <= y_d;
      idx1_q <= pos_d[P_W-1:FR_W];
      fr1_q  <= pos_d[FR_W-1:0];
    end
  end

  // ---------------- stage 2: squares, table read ----------------
  logic [31:0]         xx_w, yy_w;
  logic [CHAN_W-1:0]   sq_d, rsq_d;
  logic [CHAN_W-1:0]   xs2_q, sq2_q, rsq2_q;
  logic [FR_W-1:0]     fr2_q;
  logic [2*CHAN_W-1:0] rom_q;

  always_comb begin
    xx_w  = 32'(xs1_q) * 32'(xs1_q) + 32'd16384;
    yy_w  = 32'(y1_q) * 32'(y1_q) + 32'd16384;
    sq_d  = CHAN_W'(xx_w >> 15);
    rsq_d = CHAN_W'(32'd32768 - (yy_w >> 15));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      xs2_q  <= xs1_q;
      sq2_q  <= sq_d;
      rsq2_q <= rsq_d;
      fr2_q  <= fr1_q;
      rom_q  <= rom_w[idx1_q];
    end
  end

  // ---------------- stage 3: interpolation, three gain products ----------------
  logic [CHAN_W-1:0]        lo_w, hi_w, sm_d;
  logic [30:0]              interp_w;
  logic signed [PROD_W-1:0] g1_w, g2_w, g3_w, x_w, sq_w, rsq_w;
  logic signed [PROD_W-1:0] p1_d, p2_d, p3_d;
  logic [CHAN_W-1:0]        sm3_q;
  logic signed [PROD_W-1:0] p1_3_q, p2_3_q, p3_3_q;

  always_comb begin
    lo_w     = rom_q[2*CHAN_W-1:CHAN_W];
    hi_w     = rom_q[CHAN_W-1:0];
    interp_w = 31'(hi_w - lo_w) * 31'(fr2_q) + 31'd16384;
    // a falling pair never occurs in a sane table, keep the lower-index sample then
    sm_d     = (hi_w < lo_w) ? lo_w : lo_w + CHAN_W'(interp_w >> 15);
    g1_w     = PROD_W'($signed(gains_i.linear_gain));
    g2_w     = PROD_W'($signed(gains_i.square_gain));
    g3_w     = PROD_W'($signed(gains_i.reverse_square_gain));
    x_w      = $signed(PROD_W'(xs2_q));
    sq_w     = $signed(PROD_W'(sq2_q));
    rsq_w    = $signed(PROD_W'(rsq2_q));
    p1_d     = g1_w * x_w;
    p2_d     = g2_w * sq_w;
    p3_d     = g3_w * rsq_w;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      sm3_q  <= sm_d;
      p1_3_q <= p1_d;
      p2_3_q <= p2_d;
      p3_3_q <= p3_d;
    end
  end

  // ---------------- stage 4: sine product, first partial sums ----------------
  logic signed [PROD_W-1:0] g4_w, sm_w, p4_d;
  logic signed [ACC_W-1:0]  c0_w, s12_d, s3c_d;
  logic signed [PROD_W-1:0] p4_4_q;
  logic signed [ACC_W-1:0]  s12_4_q, s3c_4_q;

  always_comb begin
    g4_w  = PROD_W'($signed(gains_i.sine_step_gain));
    sm_w  = $signed(PROD_W'(sm3_q));
    p4_d  = g4_w * sm_w;
    c0_w  = ACC_W'($signed(gains_i.constant_gain));
    s12_d = ACC_W'(p1_3_q) + ACC_W'(p2_3_q);
    s3c_d = ACC_W'(p3_3_q) + (c0_w <<< 15);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[3]) begin
      p4_4_q  <= p4_d;
      s12_4_q <= s12_d;
      s3c_4_q <= s3c_d;
    end
  end

  // ---------------- stage 5: combine, then round and clamp to the output ----------------
  logic signed [ACC_W-1:0]  sum5_q;
  logic signed [PROD_W-1:0] p4_5_q;
  logic signed [ACC_W-1:0]  acc_w;
  logic [ACC_W-1:0]         shr_w;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[4]) begin
      sum5_q <= s12_4_q + s3c_4_q;
      p4_5_q <= p4_4_q;
    end
  end

  always_comb begin
    acc_w = sum5_q + ACC_W'(p4_5_q) + ACC_W'(2048);
    shr_w = ACC_W'(acc_w >>> 12);
    if (acc_w[ACC_W-1]) begin
      curve_o = '0;
    end else if (shr_w > ACC_W'(UNIT_Q15)) begin
      curve_o = CHAN_W'(UNIT_Q15);
    end else begin
      curve_o = shr_w[CHAN_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* sv/pixel_tone_curve_unit.sv */
// Pixel tone curve unit: four channels per item, each enabled channel mapped through a programmable curve.
// Depends on ptc_pkg, ptc_lane and pixel_tone_curve_unit_defines.svh.
//
// Usage:
//   Input channel: valid_i / stall_o with chan_*_in_i; output channel: valid_o / stall_i
//   with chan_*_out_o. An item moves at a clock edge where valid is high and stall low.
//   Gains and the channel mask sit on an APB port (word per register at 4*index); pready
//   is tied high. The user must write them only while no item is in flight; the block
//   does not enforce this. A result passes through the five datapath stages and then
//   the output register. Throughput: one item per cycle while the output is not stalled,
//   set by the fully pipelined lanes, each with its own sine table read port.
//   Each stage advances when it is empty or the stage after it advances, so bubbles are
//   squeezed out while the output is stalled; the input stalls only once every stage
//   holds an item and the receiver still stalls.
//   Reset clears all valid bits and loads the register defaults (unity linear gain,
//   all channels filtered). The sine table is constant logic and needs no fill time.
//   Channels at or above LANES, and channels whose mask bit is clear, pass their raw
//   16 bits through unchanged.
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_tone_curve_unit_defines.svh"

module pixel_tone_curve_unit
  import ptc_pkg::*;
#(
  parameter int LANES            = 4,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // APB configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  // pixel in
  input  wire logic              valid_i,
  output logic                   stall_o,
  input  wire logic [CHAN_W-1:0] chan_zero_in_i,
  input  wire logic [CHAN_W-1:0] chan_one_in_i,
  input  wire logic [CHAN_W-1:0] chan_two_in_i,
  input  wire logic [CHAN_W-1:0] chan_three_in_i,
  // pixel out
  output logic                   valid_o,
  input  wire logic              stall_i,
  output logic      [CHAN_W-1:0] chan_zero_out_o,
  output logic      [CHAN_W-1:0] chan_one_out_o,
  output logic      [CHAN_W-1:0] chan_two_out_o,
  output logic      [CHAN_W-1:0] chan_three_out_o
);

  // ---------------- configuration registers ----------------
  ptc_gains_t        gains_q;
  logic [MASK_W-1:0] cfg_mask_q;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.constant_gain       <= CONSTANT_GAIN_RST;
      gains_q.linear_gain         <= LINEAR_GAIN_RST;
      gains_q.square_gain         <= OTHER_GAIN_RST;
      gains_q.reverse_square_gain <= OTHER_GAIN_RST;
      gains_q.sine_step_gain      <= OTHER_GAIN_RST;
      cfg_mask_q                  <= CHANNEL_MASK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CONSTANT_GAIN:       gains_q.constant_gain       <= pwdata[GAIN_W-1:0];
        REG_LINEAR_GAIN:         gains_q.linear_gain         <= pwdata[GAIN_W-1:0];
        REG_SQUARE_GAIN:         gains_q.square_gain         <= pwdata[GAIN_W-1:0];
        REG_REVERSE_SQUARE_GAIN: gains_q.reverse_square_gain <= pwdata[GAIN_W-1:0];
        REG_SINE_STEP_GAIN:      gains_q.sine_step_gain      <= pwdata[GAIN_W-1:0];
        REG_CHANNEL_MASK:        cfg_mask_q                  <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CONSTANT_GAIN:       prdata = DATA_W'(gains_q.constant_gain);
      REG_LINEAR_GAIN:         prdata = DATA_W'(gains_q.linear_gain);
      REG_SQUARE_GAIN:         prdata = DATA_W'(gains_q.square_gain);
      REG_REVERSE_SQUARE_GAIN: prdata = DATA_W'(gains_q.reverse_square_gain);
      REG_SINE_STEP_GAIN:      prdata = DATA_W'(gains_q.sine_step_gain);
      REG_CHANNEL_MASK:        prdata = DATA_W'(cfg_mask_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [PIPE_STAGES-1:0] v_q;
  logic [PIPE_STAGES-1:0] en;
  ptc_ctrl_t              ctrl;

  always_comb begin
    en[PIPE_STAGES-1] = !v_q[PIPE_STAGES-1] || !stall_i;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ctrl.load = en[LANE_STAGES-1:0];
  assign stall_o   = !en[0];
  assign valid_o   = v_q[PIPE_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------- raw channel delay line ----------------
  logic [CHAN_W-1:0] chan_in [NUM_CH];
  logic [CHAN_W-1:0] raw_q   [LANE_STAGES][NUM_CH];
  logic [CHAN_W-1:0] out_q   [NUM_CH];

  assign chan_in[0] = chan_zero_in_i;
  assign chan_in[1] = chan_one_in_i;
  assign chan_in[2] = chan_two_in_i;
  assign chan_in[3] = chan_three_in_i;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      raw_q[0] <= chan_in;
    end
    for (int k = 1; k < LANE_STAGES; k++) begin
      if (en[k]) begin
        raw_q[k] <= raw_q[k-1];
      end
    end
  end

  // ---------------- lanes and output register ----------------
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_chan
    if (ch < LANES) begin : g_lane
      logic [CHAN_W-1:0] curve_w;

      ptc_lane #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
      ) u_lane (
        .clk_i  (clk_i),
        .gains_i(gains_q),
        .ctrl_i (ctrl),
        .chan_i (chan_in[ch]),
        .curve_o(curve_w)
      );

      always_ff @(posedge clk_i) begin
        if (en[PIPE_STAGES-1]) begin
          out_q[ch] <= cfg_mask_q[ch] ? curve_w : raw_q[LANE_STAGES-1][ch];
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en[PIPE_STAGES-1]) begin
          out_q[ch] <= raw_q[LANE_STAGES-1][ch];
        end
      end
    end
  end

  assign chan_zero_out_o  = out_q[0];
  assign chan_one_out_o   = out_q[1];
  assign chan_two_out_o   = out_q[2];
  assign chan_three_out_o = out_q[3];

  // ---------------- checks ----------------
  `PTC_ASSERT(a_accept_fills_s1, clk_i, rst_ni, valid_i && !stall_o |=> v_q[0], "accepted item lost at stage 1")
  `PTC_ASSERT_IMP(a_full_stalls_in, clk_i, rst_ni, (&v_q) && stall_i, stall_o, "full pipe did not stall input")
  `PTC_ASSERT_IMP(a_empty_out_ready, clk_i, rst_ni, !valid_o, !stall_o, "input stalled with empty output")
  `PTC_ASSERT_IMP(a_curve_in_range, clk_i, rst_ni, valid_o && cfg_mask_q[0], chan_zero_out_o <= 16'd32768, "filtered channel above one")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for pixel_tone_curve_unit: directed and random pixels over
// many curve settings, random idling on both sides. Depends on ptc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import ptc_pkg::*;

  localparam int      LANE_COUNT  = 4;
  localparam int      TABLE_DEPTH = 256;
  localparam longint  ONE_Q15     = 32768;
  localparam longint  ONE_Q30     = 64'sd1073741824;
  localparam longint  PI_Q30_VAL  = 64'sd3373259426;
  localparam int      RAND_PHASES = 8;
  localparam int      PHASE_ITEMS = 80;

  typedef logic [NUM_CH-1:0][CHAN_W-1:0] pixel_t;

  // Tracks the curve settings and the pixels still owed by the block.
  class tone_curve_tracker;
    longint sine_rom[TABLE_DEPTH+1];
    longint c_const, c_lin, c_sq, c_rsq, c_sine;
    logic [MASK_W-1:0] chan_mask;
    pixel_t owed_pixels[$];
    int mismatch_count;
    int error_count;

    function new();
      for (int i = 0; 2 * i <= TABLE_DEPTH; i++) begin
        sine_rom[i] = rom_sample(i);
      end
      for (int i = 0; i <= TABLE_DEPTH; i++) begin
        if (2 * i > TABLE_DEPTH) begin
          sine_rom[i] = ONE_Q15 - sine_rom[TABLE_DEPTH - i];
        end
      end
      c_const = 0;
      c_lin = 4096;
      c_sq = 0;
      c_rsq = 0;
      c_sine = 0;
      chan_mask = 4'hF;
      mismatch_count = 0;
      error_count = 0;
    endfunction

    // (1 - cos(pi*i/D))/2 in Q15 via Taylor/Horner in Q30
    function longint rom_sample(int i);
      longint divs[7];
      longint th, th2, acc, h;
      divs = '{182, 132, 90, 56, 30, 12, 2};
      th = (PI_Q30_VAL * i) / TABLE_DEPTH;
      th2 = (th * th) >>> 30;
      acc = ONE_Q30;
      for (int k = 0; k < 7; k++) begin
        acc = ONE_Q30 - ((th2 * acc) >>> 30) / divs[k];
      end
      h = ONE_Q30 - acc;
      if (h < 0) begin
        h = 0;
      end
      h = (h + 32768) >>> 16;
      if (h > 16384) begin
        h = 16384;
      end
      return h;
    endfunction

    function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_CONSTANT_GAIN:       c_const = longint'($signed(value[15:0]));
        REG_LINEAR_GAIN:         c_lin = longint'($signed(value[15:0]));
        REG_SQUARE_GAIN:         c_sq = longint'($signed(value[15:0]));
        REG_REVERSE_SQUARE_GAIN: c_rsq = longint'($signed(value[15:0]));
        REG_SINE_STEP_GAIN:      c_sine = longint'($signed(value[15:0]));
        REG_CHANNEL_MASK:        chan_mask = value[MASK_W-1:0];
        default: ;
      endcase
    endfunction

    function longint smooth_level(longint x);
      longint p, i, fr, a, b;
      p = x * TABLE_DEPTH;
      i = p >>> 15;
      fr = p & 32767;
      if (i >= TABLE_DEPTH) begin
        return sine_rom[TABLE_DEPTH];
      end
      a = sine_rom[i];
      b = sine_rom[i + 1];
      if (b < a) begin
        return a;
      end
      return a + (((b - a) * fr + 16384) >>> 15);
    endfunction

    function logic [CHAN_W-1:0] curve_value(logic [CHAN_W-1:0] raw);
      longint x, y, sq, rsq, acc;
      x = (longint'(raw) > ONE_Q15) ? ONE_Q15 : longint'(raw);
      y = ONE_Q15 - x;
      sq = (x * x + 16384) >>> 15;
      rsq = ONE_Q15 - ((y * y + 16384) >>> 15);
      acc = c_const * ONE_Q15 + c_lin * x + c_sq * sq + c_rsq * rsq
            + c_sine * smooth_level(x) + 2048;
      if (acc < 0) begin
        return '0;
      end
      acc = acc >>> 12;
      if (acc > ONE_Q15) begin
        acc = ONE_Q15;
      end
      return acc[CHAN_W-1:0];
    endfunction

    function pixel_t tone_map_pixel(pixel_t px);
      pixel_t res;
      for (int k = 0; k < NUM_CH; k++) begin
        if (k < LANE_COUNT && chan_mask[k]) begin
          res[k] = curve_value(px[k]);
        end else begin
          res[k] = px[k];
        end
      end
      return res;
    endfunction

    function void note_pixel(pixel_t px);
      owed_pixels.push_back(tone_map_pixel(px));
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (owed_pixels.size() == 0) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: unexpected output pixel %h", $realtime, got);
        end
        return;
      end
      want = owed_pixels.pop_front();
      for (int k = 0; k < NUM_CH; k++) begin
        if (got[k] !== want[k]) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: channel %0d expected %0d got %0d", $realtime, k, want[k], got[k]);
          end
        end
      end
    endfunction

    function int pending();
      return owed_pixels.size();
    endfunction

    function void close_out();
      if (owed_pixels.size() != 0) begin
        error_count++;
        $display("%0d output pixels never arrived", owed_pixels.size());
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  wire  [DATA_W-1:0] apb_rdata;
  wire               apb_ready;
  logic valid_i;
  wire  stall_o;
  pixel_t px_in;
  wire  valid_o;
  logic stall_i;
  wire  [CHAN_W-1:0] out0, out1, out2, out3;

  tone_curve_tracker tracker;
  bit src_slow;
  bit sink_slow;

  pixel_tone_curve_unit #(
    .LANES            (LANE_COUNT),
    .SINE_TABLE_DEPTH (TABLE_DEPTH)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (apb_rdata),
    .pready           (apb_ready),
    .valid_i          (valid_i),
    .stall_o          (stall_o),
    .chan_zero_in_i   (px_in[0]),
    .chan_one_in_i    (px_in[1]),
    .chan_two_in_i    (px_in[2]),
    .chan_three_in_i  (px_in[3]),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .chan_zero_out_o  (out0),
    .chan_one_out_o   (out1),
    .chan_two_out_o   (out2),
    .chan_three_out_o (out3)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int draw_gap();
    return src_slow ? $urandom_range(0, 16) : 0;
  endfunction

  // Called at a clock edge; returns at the edge where the item is taken.
  task automatic send_pixel(input pixel_t px, input int gap);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    px_in <= px;
    do @(posedge clk_i); while (stall_o);
    tracker.note_pixel(px);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    logic [DATA_W-1:0] word;
    word = {16'($urandom_range(0, 65535)), value};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!apb_ready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_reg(idx, word);
  endtask

  task automatic program_curve(input logic [15:0] g0, input logic [15:0] g1,
                               input logic [15:0] g2, input logic [15:0] g3,
                               input logic [15:0] g4, input logic [3:0] mask);
    write_reg(REG_CONSTANT_GAIN, g0);
    write_reg(REG_LINEAR_GAIN, g1);
    write_reg(REG_SQUARE_GAIN, g2);
    write_reg(REG_REVERSE_SQUARE_GAIN, g3);
    write_reg(REG_SINE_STEP_GAIN, g4);
    write_reg(REG_CHANNEL_MASK, {12'd0, mask});
  endtask

  // Pipeline must be empty before the registers change.
  task automatic settle();
    valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (PIPE_STAGES + 2) @(posedge clk_i);
  endtask

  function automatic logic [CHAN_W-1:0] draw_channel();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'h8000 : 16'h0000;
      1: return 16'($urandom_range(0, 65535));
      2: return 16'($urandom_range(0, TABLE_DEPTH) * 128 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [15:0] draw_gain(input int style);
    case (style)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 16384) - 8192);
      default: return 16'($urandom_range(0, 8192) - 4096);
    endcase
  endfunction

  // Output side: random stall per item, checks every pixel taken.
  initial begin
    int gap;
    stall_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      gap = sink_slow ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (!valid_o);
      tracker.check_pixel({out3, out2, out1, out0});
    end
  end

  initial begin
    int style;
    int pause_at;
    int drain_wait;
    pixel_t px;
    tracker = new();
    src_slow = 1'b0;
    sink_slow = 1'b0;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    valid_i <= 1'b0;
    px_in <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: identity curve, saturation above one
    send_pixel({16'd0, 16'd0, 16'd0, 16'd0}, 0);
    send_pixel({16'h8000, 16'h8000, 16'h8000, 16'h8000}, 0);
    send_pixel({16'hFFFF, 16'h8001, 16'h7FFF, 16'h0001}, 1);
    send_pixel({16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00}, 0);
    settle();

    // all terms active, channels 1 and 3 bypassed (raw bits even above one)
    program_curve(16'hF800, 16'h2000, 16'hF000, 16'h0800, 16'h1000, 4'h5);
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 0);
    send_pixel({16'h6000, 16'h2000, 16'h4000, 16'h0000}, 0);
    send_pixel({16'h7F80, 16'h8000, 16'h007F, 16'h0080}, 2);
    send_pixel({16'h1234, 16'h9ABC, 16'h4321, 16'h3FFF}, 0);
    settle();

    // gain extremes
    program_curve(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'hF);
    send_pixel({16'h8000, 16'h4000, 16'h0001, 16'h0000}, 0);
    send_pixel({16'hFFFF, 16'h0080, 16'h7FFF, 16'h2AAA}, 0);
    settle();
    program_curve(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'hF);
    send_pixel({16'h8000, 16'h4000, 16'h0001, 16'h0000}, 0);
    send_pixel({16'hFFFF, 16'h0080, 16'h7FFF, 16'h2AAA}, 0);
    settle();

    // no channel filtered
    program_curve(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0);
    send_pixel({16'hFFFF, 16'h8001, 16'h1234, 16'h0000}, 0);
    send_pixel({16'h0000, 16'h7FFE, 16'hEDCB, 16'hFFFF}, 0);
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      style = $urandom_range(0, 2);
      program_curve(draw_gain(style), draw_gain(style), draw_gain(style),
                    draw_gain(style), draw_gain(style), 4'($urandom_range(0, 15)));
      // first phases force a full pipeline and a gap-free stretch
      if (ph == 0) begin
        src_slow = 1'b0;
        sink_slow = 1'b1;
      end else if (ph == 1) begin
        src_slow = 1'b0;
        sink_slow = 1'b0;
      end else begin
        src_slow = $urandom_range(0, 2) != 0;
        sink_slow = $urandom_range(0, 2) != 0;
      end
      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == pause_at) begin
          valid_i <= 1'b0;
          do @(posedge clk_i); while (tracker.pending() != 0);
        end
        for (int k = 0; k < NUM_CH; k++) begin
          px[k] = draw_channel();
        end
        send_pixel(px, draw_gap());
      end
      settle();
    end

    drain_wait = 0;
    while (tracker.pending() != 0 && drain_wait < 5000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (PIPE_STAGES + 4) @(posedge clk_i);
    tracker.close_out();
    if (tracker.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/ptc_pkg.sv
sv/ptc_lane.sv
sv/pixel_tone_curve_unit.sv
tb/tb_top.sv
